// ===== hdl/wqsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Water quality conversion package
// Shared types, register indexes and constants.
// ----------------------------------------------------------------------------
package wqsc_pkg;

	// register indexes
	localparam logic [2:0] REG_SPR   = 3'd0;
	localparam logic [2:0] REG_TCSQ  = 3'd1;
	localparam logic [2:0] REG_TCLIN = 3'd2;
	localparam logic [2:0] REG_TCOFF = 3'd3;
	localparam logic [2:0] REG_SCALE = 3'd4;
	localparam logic [2:0] REG_TWIN  = 3'd5;
	localparam logic [2:0] REG_NWIN  = 3'd6;
	localparam logic [2:0] REG_SWIN  = 3'd7;

	// cubic constants, Q.16
	localparam logic signed [27:0] CUBIC_K3 = 28'sd8743813;
	localparam logic signed [27:0] CUBIC_K2 = 28'sd16768041;
	localparam logic signed [27:0] CUBIC_K1 = 28'sd56189911;

	localparam logic [19:0] MAX20 = 20'hFFFFF;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DIVT_INIT,
		ST_DIVT,
		ST_DIVS_INIT,
		ST_DIVS,
		ST_TQ1,
		ST_TQ2,
		ST_TQ3,
		ST_CVDIV_INIT,
		ST_CVDIV,
		ST_CB1,
		ST_CB2,
		ST_CB3,
		ST_CB4,
		ST_CB5,
		ST_FIN,
		ST_OUT
	} state_t;

	// datapath command code
	typedef enum logic [3:0] {
		OP_NONE,
		OP_DIVT_INIT,
		OP_DIVS_INIT,
		OP_CV_INIT,
		OP_DIV_STEP,
		OP_TQ1,
		OP_TQ2,
		OP_TQ3,
		OP_CB1,
		OP_CB2,
		OP_CB3,
		OP_CB4,
		OP_CB5,
		OP_FIN
	} op_t;

	typedef struct packed {
		op_t  op;
		logic acc_take;
		logic out_load;
		logic out_clear;
	} dp_cmd_t;

	typedef struct packed {
		logic batch_end;
		logic div_done;
		logic cv_ok;
		logic out_full;
	} dp_sts_t;

endpackage

// ===== hdl/wqsc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Water quality conversion datapath
// Accumulators, shared restoring divider, multiplier stages, output register.
// ----------------------------------------------------------------------------
module wqsc_datapath #(
	parameter int REF_MILLIVOLTS = 3300,
	parameter int SAMPLE_BITS    = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  wqsc_pkg::dp_cmd_t      cmd,
	output wqsc_pkg::dp_sts_t      sts,
	input  logic [11:0]            turbidity_sample,
	input  logic [11:0]            solids_sample,
	input  logic signed [11:0]     water_temperature,
	input  logic                   temperature_present,
	input  logic [6:0]             samples_per_reading,
	input  logic signed [23:0]     coeff_sq,
	input  logic signed [23:0]     coeff_lin,
	input  logic signed [23:0]     coeff_off,
	input  logic [15:0]            solids_scale,
	input  logic [31:0]            temperature_window,
	input  logic [31:0]            turbidity_window,
	input  logic [31:0]            solids_window,
	output logic [19:0]            turbidity_ntu,
	output logic [19:0]            solids_ppm,
	output logic [15:0]            compensated_voltage,
	output logic                   reading_valid
);

	localparam int SUMW  = SAMPLE_BITS + 7;
	localparam int FULL  = (1 << SAMPLE_BITS) - 1;
	localparam longint KV = longint'(REF_MILLIVOLTS) * 4096;
	// dividend width for voltage division
	localparam int NUMW  = SUMW + 26;
	localparam int DENW  = 7 + SAMPLE_BITS + 10;
	localparam int DIVW  = (NUMW > 28) ? NUMW : 28;
	localparam int CNTW  = $clog2(DIVW + 1);

	logic [SUMW-1:0] tsum_q, ssum_q;
	logic [6:0]      pairs_q;
	logic signed [11:0] temp_q;
	logic            pres_q;
	logic [6:0]      n_eff;
	logic [6:0]      pairs_nx;
	logic [11:0]     ts_c, ss_c;

	// batch length clamp, samples clamped to full scale
	always_comb begin
		if (samples_per_reading == 7'd0)
			n_eff = 7'd1;
		else if (samples_per_reading > 7'd64)
			n_eff = 7'd64;
		else
			n_eff = samples_per_reading;
		pairs_nx = pairs_q + 7'd1;
		ts_c = (int'(turbidity_sample) > FULL) ? 12'(FULL) : turbidity_sample;
		ss_c = (int'(solids_sample) > FULL) ? 12'(FULL) : solids_sample;
	end

	assign sts.batch_end = (pairs_nx >= n_eff);

	// accumulation, sums cleared at batch end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tsum_q  <= '0;
			ssum_q  <= '0;
			pairs_q <= '0;
			temp_q  <= '0;
			pres_q  <= 1'b0;
		end else if (cmd.acc_take) begin
			if (sts.batch_end) begin
				pairs_q <= '0;
				tsum_q  <= '0;
				ssum_q  <= '0;
			end else begin
				pairs_q <= pairs_nx;
				tsum_q  <= tsum_q + SUMW'(ts_c);
				ssum_q  <= ssum_q + SUMW'(ss_c);
			end
			temp_q <= water_temperature;
			pres_q <= temperature_present;
		end
	end

	// held batch sums (snapshotted at batch end)
	logic [SUMW-1:0] tbat_q, sbat_q;
	always_ff @(posedge clk) begin
		if (cmd.acc_take && sts.batch_end) begin
			tbat_q <= tsum_q + SUMW'(ts_c);
			sbat_q <= ssum_q + SUMW'(ss_c);
		end
	end

	// restoring divider, one quotient bit per cycle
	logic [DIVW-1:0] num_q, quo_q;
	logic [DIVW:0]   rem_q;
	logic [DIVW-1:0] dvs_q;
	logic [CNTW-1:0] dcnt_q;
	logic [DIVW:0]   rem_sh;
	logic signed [13:0] dcv;
	logic [DENW-1:0] den_v;

	always_comb begin
		den_v  = DENW'(n_eff) * DENW'(FULL) * DENW'(1000);
		dcv    = 14'sd400 + 14'(temp_q);
		rem_sh = {rem_q[DIVW-1:0], num_q[DIVW-1]};
	end

	assign sts.div_done = (dcnt_q == '0);
	assign sts.cv_ok    = pres_q && (dcv > 14'sd0);

	logic [15:0] vt_q, vs_q;
	logic [16:0] cv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else begin
			case (cmd.op)
				wqsc_pkg::OP_DIVT_INIT, wqsc_pkg::OP_DIVS_INIT,
				wqsc_pkg::OP_CV_INIT: dcnt_q <= CNTW'(DIVW);
				wqsc_pkg::OP_DIV_STEP: dcnt_q <= dcnt_q - 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			wqsc_pkg::OP_DIVT_INIT: begin
				num_q <= DIVW'(NUMW'(tbat_q) * NUMW'(KV) + NUMW'(den_v >> 1));
				dvs_q <= DIVW'(den_v);
				rem_q <= '0;
			end
			wqsc_pkg::OP_DIVS_INIT: begin
				vt_q  <= 16'(quo_q);
				num_q <= DIVW'(NUMW'(sbat_q) * NUMW'(KV) + NUMW'(den_v >> 1));
				dvs_q <= DIVW'(den_v);
				rem_q <= '0;
			end
			wqsc_pkg::OP_CV_INIT: begin
				num_q <= DIVW'(28'(vs_q) * 28'd800 + 28'(dcv >>> 1));
				dvs_q <= DIVW'(dcv);
				rem_q <= '0;
			end
			wqsc_pkg::OP_DIV_STEP: begin
				num_q <= num_q << 1;
				if (rem_sh >= {1'b0, dvs_q}) begin
					rem_q <= rem_sh - {1'b0, dvs_q};
					quo_q <= {quo_q[DIVW-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[DIVW-2:0], 1'b0};
				end
			end
			wqsc_pkg::OP_TQ1: vs_q <= 16'(quo_q);
			default: ;
		endcase
	end

	// turbidity polynomial and cubic, stepped by the controller's TQ and CB states
	logic signed [63:0] p_q, acc_q;
	logic signed [63:0] r1;
	logic [19:0] ntu_q, ppm_v;
	logic [16:0] cvs;

	always_comb begin
		cvs = (quo_q > DIVW'(16'hFFFF)) ? 17'h0FFFF : 17'(quo_q);
	end

	function automatic logic signed [63:0] rsh(input logic signed [63:0] x, input int s);
		logic signed [63:0] y;
		begin
			y = x + (64'sd1 <<< (s - 1));
			rsh = y >>> s;
		end
	endfunction

	function automatic logic [19:0] sat(input logic signed [63:0] v);
		begin
			if (v < 0) sat = 20'd0;
			else if (v > 64'sd1048575) sat = wqsc_pkg::MAX20;
			else sat = 20'(v);
		end
	endfunction

	always_comb r1 = acc_q + 64'sd134217728;

	always_ff @(posedge clk) begin
		case (cmd.op)
			wqsc_pkg::OP_TQ1: begin
				p_q   <= 64'(coeff_sq) * $signed({1'b0, vt_q});
				acc_q <= 64'(coeff_off) * 64'sd16777216;
			end
			wqsc_pkg::OP_TQ2: begin
				acc_q <= acc_q + p_q * $signed({1'b0, vt_q})
					+ 64'(coeff_lin) * $signed({1'b0, vt_q}) * 64'sd4096;
			end
			wqsc_pkg::OP_TQ3: begin
				ntu_q <= (acc_q <= 0) ? 20'd0 : sat(r1 >>> 28);
			end
			wqsc_pkg::OP_CB1: begin
				cv_q <= cvs;
				p_q  <= 64'(wqsc_pkg::CUBIC_K3) * $signed({47'd0, cvs})
					- 64'(wqsc_pkg::CUBIC_K2) * 64'sd4096;
			end
			wqsc_pkg::OP_CB2:
				p_q <= p_q * $signed({47'd0, cv_q}) + 64'(wqsc_pkg::CUBIC_K1) * 64'sd16777216;
			wqsc_pkg::OP_CB3: p_q <= rsh(p_q, 16) * $signed({47'd0, cv_q});
			wqsc_pkg::OP_CB4: p_q <= rsh(p_q, 16) * $signed({48'd0, solids_scale});
			wqsc_pkg::OP_CB5: p_q <= rsh(p_q, 30);
			default: ;
		endcase
	end

	// final assembly and output register
	logic out_full_q;
	logic [15:0] cv_fin;
	logic t_in, n_in, s_in;
	always_comb begin
		ppm_v  = sts.cv_ok ? sat(p_q) : 20'd0;
		cv_fin = sts.cv_ok ? cv_q[15:0] : 16'd0;
		t_in = ($signed(temp_q) >= $signed(temperature_window[15:0]))
			&& ($signed(temp_q) <= $signed(temperature_window[31:16]));
		n_in = ({1'b0, ntu_q} >= {1'b0, turbidity_window[15:0], 4'd0})
			&& ({1'b0, ntu_q} <= {1'b0, turbidity_window[31:16], 4'd0});
		s_in = ({1'b0, ppm_v} >= {1'b0, solids_window[15:0], 4'd0})
			&& ({1'b0, ppm_v} <= {1'b0, solids_window[31:16], 4'd0});
	end

	assign sts.out_full = out_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_full_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_full_q <= 1'b1;
		end else if (cmd.out_clear) begin
			out_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			turbidity_ntu       <= ntu_q;
			solids_ppm          <= ppm_v;
			compensated_voltage <= cv_fin;
			reading_valid       <= pres_q && t_in && n_in && s_in;
		end
	end

`ifndef ASSERT_OFF
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == wqsc_pkg::OP_DIV_STEP |-> dcnt_q != '0)
		else $error("divider stepped past end");
	a_pairs_range: assert property (@(posedge clk) disable iff (!arst_n)
		pairs_q <= 7'd64)
		else $error("pair count overran");
	a_no_load_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_full_q || cmd.out_clear))
		else $error("output overwritten");
`endif

endmodule

// ===== hdl/wqsc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Water quality conversion controller
// Sequences accumulation, divisions and polynomial steps.
// ----------------------------------------------------------------------------
module wqsc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              out_ready,
	output wqsc_pkg::dp_cmd_t cmd,
	input  wqsc_pkg::dp_sts_t sts
);

	wqsc_pkg::state_t state_q, state_nx;
	logic take, pop;

	assign pop  = sts.out_full && out_ready;
	assign take = in_ready && in_valid;

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			wqsc_pkg::ST_IDLE:       if (take && sts.batch_end) state_nx = wqsc_pkg::ST_DIVT_INIT;
			wqsc_pkg::ST_DIVT_INIT:  state_nx = wqsc_pkg::ST_DIVT;
			wqsc_pkg::ST_DIVT:       if (sts.div_done) state_nx = wqsc_pkg::ST_DIVS_INIT;
			wqsc_pkg::ST_DIVS_INIT:  state_nx = wqsc_pkg::ST_DIVS;
			wqsc_pkg::ST_DIVS:       if (sts.div_done) state_nx = wqsc_pkg::ST_TQ1;
			wqsc_pkg::ST_TQ1:        state_nx = wqsc_pkg::ST_TQ2;
			wqsc_pkg::ST_TQ2:        state_nx = wqsc_pkg::ST_TQ3;
			wqsc_pkg::ST_TQ3:        state_nx = wqsc_pkg::ST_CVDIV_INIT;
			wqsc_pkg::ST_CVDIV_INIT: state_nx = sts.cv_ok ? wqsc_pkg::ST_CVDIV : wqsc_pkg::ST_OUT;
			wqsc_pkg::ST_CVDIV:      if (sts.div_done) state_nx = wqsc_pkg::ST_CB1;
			wqsc_pkg::ST_CB1:        state_nx = wqsc_pkg::ST_CB2;
			wqsc_pkg::ST_CB2:        state_nx = wqsc_pkg::ST_CB3;
			wqsc_pkg::ST_CB3:        state_nx = wqsc_pkg::ST_CB4;
			wqsc_pkg::ST_CB4:        state_nx = wqsc_pkg::ST_CB5;
			wqsc_pkg::ST_CB5:        state_nx = wqsc_pkg::ST_OUT;
			wqsc_pkg::ST_OUT:        if (!sts.out_full || pop) state_nx = wqsc_pkg::ST_IDLE;
			default:                 state_nx = wqsc_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd.op        = wqsc_pkg::OP_NONE;
		cmd.acc_take  = 1'b0;
		cmd.out_load  = 1'b0;
		cmd.out_clear = pop;
		in_ready      = 1'b0;
		case (state_q)
			wqsc_pkg::ST_IDLE: begin
				in_ready     = 1'b1;
				cmd.acc_take = take;
			end
			wqsc_pkg::ST_DIVT_INIT:  cmd.op = wqsc_pkg::OP_DIVT_INIT;
			wqsc_pkg::ST_DIVS_INIT:  cmd.op = wqsc_pkg::OP_DIVS_INIT;
			wqsc_pkg::ST_CVDIV_INIT: if (sts.cv_ok) cmd.op = wqsc_pkg::OP_CV_INIT;
			wqsc_pkg::ST_DIVT, wqsc_pkg::ST_DIVS, wqsc_pkg::ST_CVDIV:
				if (!sts.div_done) cmd.op = wqsc_pkg::OP_DIV_STEP;
			wqsc_pkg::ST_TQ1: cmd.op = wqsc_pkg::OP_TQ1;
			wqsc_pkg::ST_TQ2: cmd.op = wqsc_pkg::OP_TQ2;
			wqsc_pkg::ST_TQ3: cmd.op = wqsc_pkg::OP_TQ3;
			wqsc_pkg::ST_CB1: cmd.op = wqsc_pkg::OP_CB1;
			wqsc_pkg::ST_CB2: cmd.op = wqsc_pkg::OP_CB2;
			wqsc_pkg::ST_CB3: cmd.op = wqsc_pkg::OP_CB3;
			wqsc_pkg::ST_CB4: cmd.op = wqsc_pkg::OP_CB4;
			wqsc_pkg::ST_CB5: cmd.op = wqsc_pkg::OP_CB5;
			wqsc_pkg::ST_OUT: cmd.out_load = !sts.out_full || pop;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wqsc_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

`ifndef ASSERT_OFF
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> state_q == wqsc_pkg::ST_IDLE)
		else $error("item taken while busy");
	a_load_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> sts.out_full)
		else $error("result not held");
	a_div_after_init: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == wqsc_pkg::ST_DIVT_INIT |=> state_q == wqsc_pkg::ST_DIVT)
		else $error("divider sequence broken");
`endif

endmodule

// ===== hdl/water_quality_sensor_conversion.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Water quality sensor conversion, top level
// Averages probe samples and converts them to turbidity and dissolved solids.
// ----------------------------------------------------------------------------
// channel  direction  contents
// s_axis   in         tdata: turbidity_sample, solids_sample, water_temperature,
//                     temperature_present
// m_axis   out        tdata: turbidity_ntu, solids_ppm, compensated_voltage,
//                     reading_valid
// cfg      in         index 3 bits, data 32 bits
//
// A non-final item is accepted in the idle state and added to the sums. A
// batch-end item holds off the input from its acceptance until its result
// is loaded: three restoring divisions with set-up, eight polynomial
// steps and the output load. Without a usable temperature the compensation
// division and cubic are skipped.
// Reset clears sums and control. A stalled result holds the block in its
// output state; no item is taken meanwhile.
module water_quality_sensor_conversion #(
	parameter int REF_MILLIVOLTS = 3300,
	parameter int SAMPLE_BITS    = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // ts[11:0], ss[23:12], temp[35:24], pres[36]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,  // ntu[19:0], ppm[39:20], cv[55:40], valid[56]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic [6:0]  spr_q;
	logic [23:0] csq_q, clin_q, coff_q;
	logic [15:0] scale_q;
	logic [31:0] twin_q, nwin_q, swin_q;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spr_q <= 7'd10; csq_q <= '0; clin_q <= '0; coff_q <= '0;
			scale_q <= 16'd8192; twin_q <= '0; nwin_q <= '0; swin_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				wqsc_pkg::REG_SPR:   spr_q   <= cfg_data[6:0];
				wqsc_pkg::REG_TCSQ:  csq_q   <= cfg_data[23:0];
				wqsc_pkg::REG_TCLIN: clin_q  <= cfg_data[23:0];
				wqsc_pkg::REG_TCOFF: coff_q  <= cfg_data[23:0];
				wqsc_pkg::REG_SCALE: scale_q <= cfg_data[15:0];
				wqsc_pkg::REG_TWIN:  twin_q  <= cfg_data;
				wqsc_pkg::REG_NWIN:  nwin_q  <= cfg_data;
				wqsc_pkg::REG_SWIN:  swin_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	wqsc_pkg::dp_cmd_t cmd;
	wqsc_pkg::dp_sts_t sts;

	wqsc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.out_ready(m_axis_tready), .cmd(cmd), .sts(sts)
	);

	assign m_axis_tvalid       = sts.out_full;
	assign m_axis_tdata[63:57] = '0;

	wqsc_datapath #(.REF_MILLIVOLTS(REF_MILLIVOLTS), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.turbidity_sample(s_axis_tdata[11:0]),
		.solids_sample(s_axis_tdata[23:12]),
		.water_temperature(s_axis_tdata[35:24]),
		.temperature_present(s_axis_tdata[36]),
		.samples_per_reading(spr_q),
		.coeff_sq(csq_q), .coeff_lin(clin_q), .coeff_off(coff_q),
		.solids_scale(scale_q),
		.temperature_window(twin_q), .turbidity_window(nwin_q), .solids_window(swin_q),
		.turbidity_ntu(m_axis_tdata[19:0]),
		.solids_ppm(m_axis_tdata[39:20]),
		.compensated_voltage(m_axis_tdata[55:40]),
		.reading_valid(m_axis_tdata[56])
	);

endmodule
